@@ design/btnf_pkg.sv @@
// Shared types and constants of the boundary-tag next-fit allocator.
`default_nettype none
package btnf_pkg;

    localparam int ARENA_WORDS_DEF = 4096;
    localparam int WORD_BYTES_DEF  = 8;

    localparam int OP_W     = 2;
    localparam int BYTES_W  = 16;
    localparam int ADDR_W   = 13;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 12;
    localparam int FREE_W   = 13;
    localparam int CFG_W    = 16;
    // command positions and word counts, wide enough for the largest arena
    localparam int POS_W    = 17;

    localparam logic [CFG_W-1:0] MAX_REQ_RESET = 16'd32768;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_PERM  = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_SIZE = 3'd1;
    localparam t_status ST_NO_SPACE = 3'd2;
    localparam t_status ST_OUTSIDE  = 3'd3;
    localparam t_status ST_ILLEGAL  = 3'd4;
    localparam t_status ST_DBL_FREE = 3'd5;

    typedef enum logic [1:0] {
        K_DONE  = 2'd0,
        K_ALLOC = 2'd1,
        K_PERM  = 2'd2,
        K_FREE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [POS_W-1:0]  words;
        logic [POS_W-1:0]  pos;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [GRANT_W-1:0]  granted;
        logic [FREE_W-1:0]   free_words;
    } t_res;

endpackage
`default_nettype wire

@@ design/btnf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btnf_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/btnf_fifo.sv @@
// Small register queue used between the front, the back and the result port.
`default_nettype none
module btnf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

@@ design/btnf_front.sv @@
// Front end: size limit register, request classification, command queue.
`default_nettype none
module btnf_front
    import btnf_pkg::*;
#(
    parameter int ARENA_WORDS = ARENA_WORDS_DEF,
    parameter int WORD_BYTES  = WORD_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_hold,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [BYTES_W-1:0] i_request_bytes,
    input  wire logic [ADDR_W-1:0]  i_free_address,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic               i_cmd_pop,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd
);
    // exact ceiling reciprocal for any request up to 17 bits
    localparam int  K     = 22;
    localparam int  RW    = K - 1;
    localparam longint RECIP = ((64'd1 << K) + WORD_BYTES - 1) / WORD_BYTES;
    localparam int  NW    = BYTES_W + 1;

    logic [CFG_W-1:0]   r_max_req;
    logic [NW-1:0]      rounded;
    logic [NW+RW-1:0]   prod;
    logic [POS_W-1:0]   words;
    t_cmd               cmd;
    logic               q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= MAX_REQ_RESET;
        end else if (i_cfg_we) begin
            r_max_req <= i_cfg_wdata;
        end
    end

    assign rounded = {1'b0, i_request_bytes} + NW'(WORD_BYTES - 1);
    assign prod    = rounded * RW'(RECIP);
    assign words   = POS_W'(prod[NW+RW-1:K]) + POS_W'(1);

    always_comb begin
        cmd.kind   = K_DONE;
        cmd.status = ST_OK;
        cmd.words  = words;
        cmd.pos    = '0;
        unique case (t_op'(i_operation)) inside
            OP_ALLOC, OP_PERM: begin
                if (i_request_bytes == '0 || i_request_bytes > r_max_req) begin
                    cmd.status = ST_BAD_SIZE;
                end else begin
                    cmd.kind = (t_op'(i_operation) == OP_ALLOC) ? K_ALLOC : K_PERM;
                end
            end
            OP_FREE: begin
                if (32'(i_free_address) >= ARENA_WORDS) begin
                    cmd.status = ST_OUTSIDE;
                end else if (i_free_address == '0) begin
                    cmd.status = ST_ILLEGAL;
                end else begin
                    cmd.kind = K_FREE;
                    cmd.pos  = POS_W'(i_free_address) - POS_W'(1);
                end
            end
            default: begin
                cmd.status = ST_OK;
            end
        endcase
    end

    assign o_full      = q_full || i_hold;
    assign o_cmd_valid = !q_empty;

    btnf_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_wdata (cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (o_cmd),
        .o_empty (q_empty)
    );
endmodule
`default_nettype wire

@@ design/btnf_back.sv @@
// Back end: header memory, next-fit walk with merging, carve and free sequencer.
`default_nettype none
module btnf_back
    import btnf_pkg::*;
#(
    parameter int ARENA_WORDS = ARENA_WORDS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    output logic      o_clearing,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_res      o_res
);
    localparam int LG = $clog2(ARENA_WORDS);
    localparam int HW = LG + 2;
    localparam int CW = (LG + 6 > 18) ? LG + 6 : 18;
    localparam logic signed [CW-1:0] A     = CW'(ARENA_WORDS);
    localparam logic signed [CW-1:0] LIMIT = CW'(4 * ARENA_WORDS + 8);
    localparam logic signed [CW-1:0] LIMC  = CW'(8 * ARENA_WORDS);

    typedef enum logic [14:0] {
        S_CLR   = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_FETCH = 15'b000000000000100,
        S_FREE  = 15'b000000000001000,
        S_TAKE  = 15'b000000000010000,
        S_TCHK  = 15'b000000000100000,
        S_W1    = 15'b000000001000000,
        S_W2    = 15'b000000010000000,
        S_PUT   = 15'b000000100000000,
        S_CARVE = 15'b000001000000000,
        S_SPLIT = 15'b000010000000000,
        S_PCHK  = 15'b000100000000000,
        S_PPUT  = 15'b001000000000000,
        S_FIN   = 15'b010000000000000,
        S_SPARE = 15'b100000000000000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    t_status r_status, n_status;
    logic   r_sought, n_sought;
    logic signed [CW-1:0] r_c, n_c, r_start, n_start, r_sum, n_sum;
    logic signed [CW-1:0] r_shift, n_shift, r_steps, n_steps, r_w, n_w;
    logic signed [CW-1:0] r_rover, n_rover, r_top, n_top;
    logic signed [CW-1:0] r_lower, n_lower, r_upper, n_upper, r_free, n_free;
    logic signed [CW-1:0] r_granted, n_granted, r_sz, n_sz;

    logic [HW-1:0]        rdata;
    logic signed [CW-1:0] hv, adv_c, span, nc, sh, up, lo, rv, wa, cf, fw;
    logic                 we;
    logic signed [CW-1:0] wd;

    function automatic logic signed [CW-1:0] adv(input logic signed [CW-1:0] c,
                                                 input logic signed [CW-1:0] h);
        logic signed [CW-1:0] m;
        m = (h < 0) ? -h : h;
        if (m == '0 || m > A - c) begin
            return A;
        end
        return c + m;
    endfunction

    function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v);
        if (v > LIMC) begin
            return LIMC;
        end
        if (v < -LIMC) begin
            return -LIMC;
        end
        return v;
    endfunction

    btnf_ram #(
        .WIDTH (HW),
        .DEPTH (ARENA_WORDS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (we && wa >= 0 && wa < A),
        .i_waddr (wa[LG-1:0]),
        .i_wdata (wd[HW-1:0]),
        .i_raddr (r_c[LG-1:0]),
        .o_rdata (rdata)
    );

    // the position one past the arena reads as an empty header
    assign hv    = (r_c >= A) ? '0 : {{(CW-HW){rdata[HW-1]}}, rdata};
    assign adv_c = adv(r_c, hv);
    assign span  = adv_c - r_c;
    assign o_clearing = (r_state == S_CLR);

    always_comb begin
        n_state = r_state;   n_ret = r_ret;
        n_status = r_status; n_sought = r_sought; n_c = r_c;
        n_start = r_start;   n_sum = r_sum;       n_shift = r_shift;
        n_steps = r_steps;   n_w = r_w;           n_rover = r_rover;
        n_top = r_top;       n_lower = r_lower;   n_upper = r_upper;
        n_free = r_free;     n_granted = r_granted; n_sz = r_sz;
        we = 1'b0; wa = r_c; wd = '0;
        o_cmd_pop = 1'b0; o_res_push = 1'b0;
        nc = '0; sh = '0; up = '0; lo = '0; rv = '0; cf = '0; fw = '0;
        o_res = '0;
        unique case (r_state)
            S_CLR: begin
                we = 1'b1;
                wd = (r_c == '0) ? A : '0;
                n_c = r_c + 1;
                if (r_c == A - 1) begin
                    n_c = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_status = i_cmd.status;
                    n_w = CW'(i_cmd.words);
                    n_granted = '0;
                    n_sought = 1'b0;
                    unique case (i_cmd.kind)
                        K_DONE: n_state = S_FIN;
                        K_FREE: begin
                            n_c = CW'(i_cmd.pos);
                            n_ret = S_FREE;
                            n_state = S_FETCH;
                        end
                        K_ALLOC: n_state = S_TAKE;
                        K_PERM: begin
                            n_c = r_top;
                            n_ret = S_PCHK;
                            n_state = S_FETCH;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_FETCH: begin
                n_state = r_ret;
            end
            S_FREE: begin
                if (hv == '0) begin
                    n_status = ST_ILLEGAL;
                end else if (hv > 0) begin
                    n_status = ST_DBL_FREE;
                end else begin
                    we = 1'b1;
                    wd = -hv;
                    n_free = r_free - hv;
                    if (r_c < r_rover) begin
                        n_lower = r_lower - hv;
                    end else begin
                        n_upper = r_upper - hv;
                    end
                end
                n_state = S_FIN;
            end
            S_TAKE: begin
                if (r_upper <= r_lower) begin
                    n_rover = '0;
                    n_upper = r_upper + r_lower;
                    n_lower = '0;
                    n_c = '0;
                end else begin
                    n_c = r_rover;
                end
                n_ret = S_TCHK;
                n_state = S_FETCH;
            end
            S_TCHK: begin
                if (hv >= r_w) begin
                    n_state = S_CARVE;
                end else if (r_sought) begin
                    n_status = ST_NO_SPACE;
                    n_state = S_FIN;
                end else begin
                    n_shift = '0;
                    n_steps = '0;
                    n_state = S_W1;
                end
            end
            S_W1: begin
                // skip used chunks
                n_state = S_FETCH;
                if (hv < 0) begin
                    nc = adv_c;
                    if (nc == A) begin
                        nc = '0;
                        n_shift = -r_lower;
                    end
                    n_c = nc;
                    if (nc == r_rover) begin
                        n_sought = 1'b1;
                        n_ret = S_TCHK;
                    end else if (r_steps + 1 > LIMIT) begin
                        n_c = A;
                        n_sought = 1'b1;
                        n_ret = S_TCHK;
                    end else begin
                        n_steps = r_steps + 1;
                        n_ret = S_W1;
                    end
                end else begin
                    n_start = r_c;
                    n_sum = span;
                    n_c = adv_c;
                    n_ret = S_W2;
                end
            end
            S_W2: begin
                // merge following free chunks
                if (r_c != A && hv > 0) begin
                    n_state = S_FETCH;
                    if (r_steps + 1 > LIMIT) begin
                        n_c = A;
                        n_sought = 1'b1;
                        n_ret = S_TCHK;
                    end else begin
                        n_steps = r_steps + 1;
                        n_sum = r_sum + span;
                        if (r_c == r_rover) begin
                            n_rover = adv_c;
                            n_upper = r_upper - span;
                            n_lower = r_lower + span;
                            n_shift = r_shift - span;
                        end
                        if (r_c == r_top) begin
                            n_top = r_start;
                        end
                        n_c = adv_c;
                        n_ret = S_W2;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we = 1'b1;
                wa = r_start;
                wd = r_sum;
                sh = r_shift + ((r_sum < r_w) ? r_sum : '0);
                nc = r_c; rv = r_rover; up = r_upper; lo = r_lower;
                if (r_c == A) begin
                    nc = '0;
                    if (r_rover == A) begin
                        rv = '0;
                        up = r_upper + r_lower;
                        lo = '0;
                        sh = '0;
                    end else begin
                        sh = -r_lower;
                    end
                end
                n_rover = rv; n_upper = up; n_lower = lo; n_shift = sh;
                n_state = S_FETCH;
                if (r_steps + 1 > LIMIT) begin
                    n_c = A;
                    n_sought = 1'b1;
                    n_ret = S_TCHK;
                end else begin
                    n_steps = r_steps + 1;
                    n_c = nc;
                    if (r_sum < r_w && nc != rv) begin
                        n_ret = S_W1;
                    end else if (r_sum < r_w) begin
                        n_sought = 1'b1;
                        n_ret = S_TCHK;
                    end else begin
                        n_lower = lo + sh;
                        n_upper = up - sh;
                        n_rover = r_start;
                        n_c = r_start;
                        n_sought = 1'b1;
                        n_ret = S_TCHK;
                    end
                end
            end
            S_CARVE: begin
                we = 1'b1;
                wd = -r_w;
                nc = r_c + r_w;
                if (r_c == r_top && nc != A) begin
                    n_top = r_top + r_w;
                end
                up = r_upper - r_w;
                n_free = r_free - r_w;
                n_granted = r_c + 1;
                n_sz = hv - r_w;
                n_rover = nc;
                n_state = S_FIN;
                if (hv > r_w) begin
                    n_c = nc;
                    n_state = S_SPLIT;
                end else if (nc == A) begin
                    n_rover = '0;
                    up = r_lower;
                    n_lower = '0;
                end
                n_upper = up;
            end
            S_SPLIT: begin
                we = 1'b1;
                wd = r_sz;
                n_state = S_FIN;
            end
            S_PCHK: begin
                if (hv < r_w) begin
                    n_state = S_TAKE;
                end else begin
                    n_upper = r_upper - r_w;
                    n_free = r_free - r_w;
                    we = 1'b1;
                    if (hv > r_w) begin
                        wd = hv - r_w;
                        n_c = r_c + hv - r_w;
                        n_state = S_PPUT;
                    end else begin
                        wd = -r_w;
                        n_granted = r_c + 1;
                        n_state = S_FIN;
                    end
                end
            end
            S_PPUT: begin
                we = 1'b1;
                wd = -r_w;
                n_granted = r_c + 1;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_lower = clampc(r_lower);
                n_upper = clampc(r_upper);
                cf = clampc(r_free);
                n_free = cf;
                fw = (cf < 0) ? '0 : ((cf > A) ? A : cf);
                o_res.status = r_status;
                o_res.granted = GRANT_W'(r_granted);
                o_res.free_words = FREE_W'(fw);
                o_res_push = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_c     <= '0;
            r_rover <= '0;
            r_top   <= '0;
            r_lower <= '0;
            r_upper <= A;
            r_free  <= A;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_c     <= n_c;
            r_rover <= n_rover;
            r_top   <= n_top;
            r_lower <= n_lower;
            r_upper <= n_upper;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_sought  <= n_sought;
        r_start   <= n_start;
        r_sum     <= n_sum;
        r_shift   <= n_shift;
        r_steps   <= n_steps;
        r_w       <= n_w;
        r_granted <= n_granted;
        r_sz      <= n_sz;
    end
endmodule
`default_nettype wire

@@ design/boundary_tag_next_fit_allocator.sv @@
// Top level: front classifier, allocation engine and result queue.
// The engine handles one item at a time; each header visit is a RAM read through S_FETCH.
// The front queues up to two items, so push is taken while the engine works.
// Reset: synchronous, active low; a clearing pass over every header word follows, full high.
`default_nettype none
module boundary_tag_next_fit_allocator
    import btnf_pkg::*;
#(
    parameter int ARENA_WORDS = ARENA_WORDS_DEF,
    parameter int WORD_BYTES  = WORD_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [BYTES_W-1:0]  i_request_bytes,
    input  wire logic [ADDR_W-1:0]   i_free_address,
    output logic                     empty,
    input  wire logic                pop,
    output logic [STATUS_W-1:0]      o_status,
    output logic [GRANT_W-1:0]       o_granted_address,
    output logic [FREE_W-1:0]        o_free_words,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata
);
    t_cmd cmd;
    t_res res_in, res_out;
    logic cmd_valid, cmd_pop, clearing, res_push, res_full;

    btnf_front #(
        .ARENA_WORDS (ARENA_WORDS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hold          (clearing),
        .i_push          (push),
        .o_full          (full),
        .i_operation     (i_operation),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_pop       (cmd_pop),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd)
    );

    btnf_back #(
        .ARENA_WORDS (ARENA_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    btnf_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign o_status          = res_out.status;
    assign o_granted_address = res_out.granted;
    assign o_free_words      = res_out.free_words;
endmodule
`default_nettype wire

@@ design/btnf_checker.sv @@
// Port-level checks of the allocator and their bind to the top level.
`default_nettype none
module btnf_checker
    import btnf_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [GRANT_W-1:0]  o_granted_address,
    input wire logic [FREE_W-1:0]   o_free_words
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status <= ST_DBL_FREE)
        else $error("status code out of range");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> o_granted_address == '0)
        else $error("address granted on a failed item");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_free_words <= FREE_W'(ARENA_WORDS_DEF))
        else $error("free word count above arena size");

    a_reset_clear: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && full))
        else $error("queue not empty or input open right after reset");
endmodule

bind boundary_tag_next_fit_allocator btnf_checker u_btnf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .o_status          (o_status),
    .o_granted_address (o_granted_address),
    .o_free_words      (o_free_words)
);
`default_nettype wire
